// ===== src/periodic_on_off_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// periodic_on_off_scheduler_top_macros.svh
// assertion helpers used by the scheduler top
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ON_OFF_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_ON_OFF_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define POSCH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define POSCH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/posch_pkg.sv =====
// ----------------------------------------------------------------------------
// posch_pkg
// shared widths, register codes and control structs of the on/off scheduler
// ----------------------------------------------------------------------------
package posch_pkg;

	// field widths
	localparam int DUR_W    = 24;
	localparam int PERIOD_W = DUR_W + 1;
	localparam int NOW_W    = 32;
	localparam int ID_W     = 8;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 4;

	// register indexes, taken from paddr[3:2]
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_ON_DURATION = 2'd0;
	localparam reg_idx_t REG_OFF_INTERVAL = 2'd1;
	localparam reg_idx_t REG_FIRST_EVENT = 2'd2;
	localparam reg_idx_t REG_EVENT_NUMBER = 2'd3;

	// remainder unit control and status
	typedef struct packed {
		logic start;
	} posch_rem_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} posch_rem_stat_t;

endpackage

// ===== src/posch_rem_unit.sv =====
// ----------------------------------------------------------------------------
// posch_rem_unit
// bit-serial restoring remainder unit: one dividend bit per cycle
// ----------------------------------------------------------------------------
module posch_rem_unit #(
	parameter int TIME_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  posch_pkg::posch_rem_ctrl_t       ctrl,
	input  logic [TIME_BITS-1:0]             dividend,
	input  logic [posch_pkg::PERIOD_W-1:0]   divisor,
	output logic [posch_pkg::PERIOD_W-1:0]   rem,
	output posch_pkg::posch_rem_stat_t       stat
);
	import posch_pkg::*;

	localparam int CNT_W = $clog2(TIME_BITS);

	logic [TIME_BITS-1:0] dvd_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [PERIOD_W:0]    shifted;
	logic [PERIOD_W+1:0]  diff;

	// trial subtract of the divisor from the shifted partial remainder
	assign shifted = {rem_q, dvd_q[TIME_BITS-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TIME_BITS - 1);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (busy_q) begin
			dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
			if (!diff[PERIOD_W+1]) begin
				rem_q <= diff[PERIOD_W-1:0];
			end else begin
				rem_q <= shifted[PERIOD_W-1:0];
			end
		end else if (ctrl.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end
	end

	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== src/periodic_on_off_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// periodic_on_off_scheduler_top
// on/off edge scheduler with catch-up over missed periods
// ----------------------------------------------------------------------------
// Usage: each request on the now channel (now_valid, now_stall, now_time)
// carries the current time. The block answers every request with exactly one
// result on the res channel (activate_pulse, deactivate_pulse, action_id,
// active_now, period_error). The APB port holds on_duration, off_interval,
// first_event_time (a write also loads the next edge time) and event_number;
// write it only while no request is in flight.
// Flow: a request with a zero period or an edge not yet due goes from
// CHECK straight to DONE; a due edge also passes DIV, BASE, PHASE and EDGE,
// and in DIV the bit-serial remainder unit retires one time bit per cycle.
// now_stall stays high while a request is being worked, so one request is
// in flight at a time; the next request is taken at the edge after res_valid
// rises. A finished result waits in the output register; the next request is
// taken while it waits, and a second result holds until res_stall drops.
// Reset clears the APB registers, the next edge time and the active flag.
// ----------------------------------------------------------------------------
`include "periodic_on_off_scheduler_top_macros.svh"

module periodic_on_off_scheduler_top #(
	parameter int TIME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              now_valid,
	output logic                              now_stall,
	input  logic [posch_pkg::NOW_W-1:0]       now_time,
	// result channel
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              activate_pulse,
	output logic                              deactivate_pulse,
	output logic [posch_pkg::ID_W-1:0]        action_id,
	output logic                              active_now,
	output logic                              period_error,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [posch_pkg::PADDR_W-1:0]     paddr,
	input  logic [posch_pkg::DATA_W-1:0]      pwdata,
	output logic [posch_pkg::DATA_W-1:0]      prdata,
	output logic                              pready
);
	import posch_pkg::*;

	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_BASE  = 3'd3;
	localparam logic [2:0] ST_PHASE = 3'd4;
	localparam logic [2:0] ST_EDGE  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]           state_q;

	// registers
	logic [DUR_W-1:0]     on_duration_q;
	logic [DUR_W-1:0]     off_interval_q;
	logic [NOW_W-1:0]     first_event_q;
	logic [ID_W-1:0]      event_number_q;

	// scheduler state
	logic [TIME_BITS-1:0] next_q;
	logic                 active_q;
	logic [TIME_BITS-1:0] now_q;

	// pending result
	logic                 res_act_q;
	logic                 res_deact_q;
	logic                 res_err_q;

	// output register
	logic                 out_valid_q;
	logic                 out_act_q;
	logic                 out_deact_q;
	logic [ID_W-1:0]      out_id_q;
	logic                 out_active_q;
	logic                 out_err_q;

	logic                 cfg_wr;
	reg_idx_t             cfg_idx;
	logic                 now_acc;
	logic                 res_acc;
	logic [PERIOD_W-1:0]  period;
	logic                 due;
	logic [DUR_W-1:0]     phase_b;
	logic                 phase_hit;
	logic [DUR_W-1:0]     edge_b;
	logic [TIME_BITS-1:0] edge_sum;
	logic [TIME_BITS-1:0] phase_sum;

	posch_rem_ctrl_t      rem_ctrl;
	posch_rem_stat_t      rem_stat;
	logic [PERIOD_W-1:0]  rem;

	// handshakes
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign cfg_idx   = paddr[3:2];
	assign now_stall = (state_q != ST_IDLE);
	assign now_acc   = now_valid && !now_stall;
	assign res_acc   = out_valid_q && !res_stall;
	assign pready    = 1'b1;

	// period and due test
	assign period = {1'b0, on_duration_q} + {1'b0, off_interval_q};
	assign due    = (next_q <= now_q);

	// phase correction: one add and one compare against the current phase length
	assign phase_b   = active_q ? off_interval_q : on_duration_q;
	assign phase_hit = (rem >= {1'b0, phase_b});
	assign phase_sum = next_q + TIME_BITS'(phase_b);

	// edge: on length only when turning on with a nonzero on duration
	assign edge_b   = (!active_q && (on_duration_q != '0)) ? on_duration_q : off_interval_q;
	assign edge_sum = next_q + TIME_BITS'(edge_b);

	assign rem_ctrl.start = (state_q == ST_CHECK) && (period != '0) && due;

	posch_rem_unit #(
		.TIME_BITS (TIME_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (rem_ctrl),
		.dividend (now_q - next_q),
		.divisor  (period),
		.rem      (rem),
		.stat     (rem_stat)
	);

	// register read
	always_comb begin
		case (cfg_idx)
			REG_ON_DURATION:  prdata = DATA_W'(on_duration_q);
			REG_OFF_INTERVAL: prdata = DATA_W'(off_interval_q);
			REG_FIRST_EVENT:  prdata = DATA_W'(first_event_q);
			REG_EVENT_NUMBER: prdata = DATA_W'(event_number_q);
			default:          prdata = '0;
		endcase
	end

	// register write and scheduler sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_duration_q  <= '0;
			off_interval_q <= '0;
			first_event_q  <= '0;
			event_number_q <= '0;
			next_q         <= '0;
			active_q       <= 1'b0;
			state_q        <= ST_IDLE;
			res_act_q      <= 1'b0;
			res_deact_q    <= 1'b0;
			res_err_q      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_ON_DURATION:  on_duration_q  <= pwdata[DUR_W-1:0];
					REG_OFF_INTERVAL: off_interval_q <= pwdata[DUR_W-1:0];
					REG_FIRST_EVENT: begin
						first_event_q <= pwdata[NOW_W-1:0];
						next_q        <= TIME_BITS'(pwdata[NOW_W-1:0]);
					end
					REG_EVENT_NUMBER: event_number_q <= pwdata[ID_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (now_acc) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					res_act_q   <= 1'b0;
					res_deact_q <= 1'b0;
					res_err_q   <= (period == '0);
					if ((period != '0) && due) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (rem_stat.done) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					// last period start not after now
					next_q  <= now_q - TIME_BITS'(rem);
					state_q <= ST_PHASE;
				end
				ST_PHASE: begin
					if (phase_hit) begin
						next_q   <= phase_sum;
						active_q <= !active_q;
					end
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					next_q      <= edge_sum;
					res_act_q   <= !active_q;
					res_deact_q <= active_q;
					active_q    <= !active_q && (on_duration_q != '0);
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !res_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request time capture
	always_ff @(posedge clk) begin
		if (now_acc) begin
			now_q <= TIME_BITS'(now_time);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || !res_stall)) begin
			out_valid_q <= 1'b1;
		end else if (res_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || !res_stall)) begin
			out_act_q    <= res_act_q;
			out_deact_q  <= res_deact_q;
			out_id_q     <= event_number_q;
			out_active_q <= active_q;
			out_err_q    <= res_err_q;
		end
	end

	assign res_valid        = out_valid_q;
	assign activate_pulse   = out_act_q;
	assign deactivate_pulse = out_deact_q;
	assign action_id        = out_id_q;
	assign active_now       = out_active_q;
	assign period_error     = out_err_q;

	// checks
	`POSCH_ASSERT_IMP(a_err_no_pulse, clk, arst_n, res_valid && period_error,
		!activate_pulse && !deactivate_pulse, "pulse with period error")
	`POSCH_ASSERT_IMP(a_pulse_excl, clk, arst_n, res_valid,
		!(activate_pulse && deactivate_pulse), "both pulses set")
	`POSCH_ASSERT_IMP(a_deact_inactive, clk, arst_n, res_valid && deactivate_pulse,
		!active_now, "active after deactivate")
	`POSCH_ASSERT_NXT(a_accept_check, clk, arst_n, now_acc, state_q == ST_CHECK,
		"request not checked")

endmodule

// ===== test/on_off_checker.sv =====
// ----------------------------------------------------------------------------
// on_off_checker
// watches the scheduler channels, predicts each result and compares it
// ----------------------------------------------------------------------------
// Tracks register writes on the APB port, keeps its own copy of the next
// edge time and the active flag, and queues one expected result per accepted
// request. Each accepted result is checked field by field against the oldest
// expectation. fail_count and pending go back to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module on_off_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          now_valid,
	input  logic                          now_stall,
	input  logic [posch_pkg::NOW_W-1:0]   now_time,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  logic                          activate_pulse,
	input  logic                          deactivate_pulse,
	input  logic [posch_pkg::ID_W-1:0]    action_id,
	input  logic                          active_now,
	input  logic                          period_error,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [posch_pkg::PADDR_W-1:0] paddr,
	input  logic [posch_pkg::DATA_W-1:0]  pwdata,
	input  logic                          pready,
	output int                            fail_count,
	output int                            pending
);
	import posch_pkg::*;

	typedef struct packed {
		logic            act;
		logic            deact;
		logic [ID_W-1:0] id;
		logic            active;
		logic            err;
	} sched_result_t;

	// register copies and schedule state
	logic [DUR_W-1:0] cfg_on;
	logic [DUR_W-1:0] cfg_off;
	logic [ID_W-1:0]  cfg_event;
	logic [NOW_W-1:0] edge_time;
	logic             on_state;

	sched_result_t expected_q[$];

	// one scheduling check at time t, updates edge_time and on_state
	function automatic sched_result_t advance_schedule(input logic [NOW_W-1:0] t);
		sched_result_t r;
		logic [PERIOD_W-1:0] per;
		logic [NOW_W-1:0] lag;
		logic [NOW_W-1:0] whole;
		per = PERIOD_W'(cfg_on) + PERIOD_W'(cfg_off);
		r = '0;
		r.id = cfg_event;
		if (per == '0) begin
			r.err = 1'b1;
		end else if (edge_time <= t) begin
			// catch up by whole periods
			lag = t - edge_time;
			whole = lag - (lag % per);
			edge_time = edge_time + whole;
			lag = lag - whole;
			// phase correction when late within the period
			if (on_state) begin
				if (lag >= cfg_off) begin
					edge_time = edge_time + cfg_off;
					on_state = 1'b0;
				end
			end else if (lag >= cfg_on) begin
				edge_time = edge_time + cfg_on;
				on_state = 1'b1;
			end
			// emit the edge and schedule the next one
			if (!on_state) begin
				r.act = 1'b1;
				if (cfg_on == '0) begin
					edge_time = edge_time + cfg_off;
				end else begin
					on_state = 1'b1;
					edge_time = edge_time + cfg_on;
				end
			end else begin
				r.deact = 1'b1;
				on_state = 1'b0;
				edge_time = edge_time + cfg_off;
			end
		end
		r.active = on_state;
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [ID_W-1:0] want,
			input logic [ID_W-1:0] got);
		if (got !== want) begin
			$display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	// register tracking, prediction and comparison
	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		if (!arst_n) begin
			cfg_on = '0;
			cfg_off = '0;
			cfg_event = '0;
			edge_time = '0;
			on_state = 1'b0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_ON_DURATION: cfg_on = pwdata[DUR_W-1:0];
					REG_OFF_INTERVAL: cfg_off = pwdata[DUR_W-1:0];
					REG_FIRST_EVENT: edge_time = pwdata[NOW_W-1:0];
					REG_EVENT_NUMBER: cfg_event = pwdata[ID_W-1:0];
					default: ;
				endcase
			end
			if (now_valid && !now_stall)
				expected_q.push_back(advance_schedule(now_time));
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected result: expected none, %s act=%0b deact=%0b id=%0h",
						$time, "actual", activate_pulse, deactivate_pulse, action_id);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					compare_field("activate_pulse", ID_W'(want.act), ID_W'(activate_pulse));
					compare_field("deactivate_pulse", ID_W'(want.deact),
						ID_W'(deactivate_pulse));
					compare_field("action_id", want.id, action_id);
					compare_field("active_now", ID_W'(want.active), ID_W'(active_now));
					compare_field("period_error", ID_W'(want.err), ID_W'(period_error));
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

// ===== test/tb_periodic_on_off_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// tb_periodic_on_off_scheduler_top
// stimulus and verdict for the periodic on/off scheduler
// ----------------------------------------------------------------------------
// Drives time requests with random gaps and random result stalls, rewrites
// the registers between phases, and lets on_off_checker predict and compare.
// A short directed part covers the special cases, then random phases walk
// the time forward with catch-up jumps, wraps and noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_periodic_on_off_scheduler_top;
	import posch_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 50;
	localparam int LONG_HOLD    = 300;
	localparam int PHASES       = 14;
	localparam int PHASE_ITEMS  = 110;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               now_valid = 1'b0;
	logic               now_stall;
	logic [NOW_W-1:0]   now_time = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic               activate_pulse;
	logic               deactivate_pulse;
	logic [ID_W-1:0]    action_id;
	logic               active_now;
	logic               period_error;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int gap_max = 10;

	always #5 clk = ~clk;

	periodic_on_off_scheduler_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.now_valid        (now_valid),
		.now_stall        (now_stall),
		.now_time         (now_time),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.activate_pulse   (activate_pulse),
		.deactivate_pulse (deactivate_pulse),
		.action_id        (action_id),
		.active_now       (active_now),
		.period_error     (period_error),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	on_off_checker sched_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.now_valid        (now_valid),
		.now_stall        (now_stall),
		.now_time         (now_time),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.activate_pulse   (activate_pulse),
		.deactivate_pulse (deactivate_pulse),
		.action_id        (action_id),
		.active_now       (active_now),
		.period_error     (period_error),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.pready           (pready),
		.fail_count       (fail_count),
		.pending          (pending)
	);

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stop offering and wait until every result is back
	task automatic drain_results();
		now_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// setup and access phase, leaves psel high
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// all four registers, unused upper data bits randomized
	task automatic apply_settings(input logic [DUR_W-1:0] on_len,
			input logic [DUR_W-1:0] off_len, input logic [NOW_W-1:0] first,
			input logic [ID_W-1:0] evn);
		drain_results();
		write_reg(REG_ON_DURATION, {8'($urandom), on_len});
		write_reg(REG_OFF_INTERVAL, {8'($urandom), off_len});
		write_reg(REG_FIRST_EVENT, first);
		write_reg(REG_EVENT_NUMBER, {24'($urandom), evn});
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// one time request after a random gap
	task automatic offer_time(input logic [NOW_W-1:0] t);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			now_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		now_valid <= 1'b1;
		now_time <= t;
		do @(posedge clk); while (now_stall);
	endtask

	// result side stalls, with long holds to fill the block
	initial begin : result_sink
		int hold;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			if (taken == 300 || taken == 1000)
				hold = LONG_HOLD;
			else
				hold = $urandom_range(0, gap_max);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
			taken++;
		end
	end

	// stimulus
	initial begin : time_source
		logic [DUR_W-1:0]    on_len;
		logic [DUR_W-1:0]    off_len;
		logic [PERIOD_W-1:0] per;
		logic [NOW_W-1:0]    base;
		logic [NOW_W-1:0]    clock_now;
		logic [NOW_W-1:0]    step_max;
		int sel;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero period straight after reset
		offer_time('0);
		offer_time(32'hFFFF_FFFF);

		// not due, due, deactivate, late within a period, catch-up
		apply_settings(24'd3, 24'd5, 32'd10, 8'hA5);
		offer_time(32'd0);
		offer_time(32'd9);
		offer_time(32'd10);
		offer_time(32'd13);
		offer_time(32'd20);
		offer_time(32'd100);
		offer_time(32'hFFFF_FFFF);

		// pulse only, with the next edge wrapping past the top
		apply_settings(24'd0, 24'd4, 32'hFFFF_FFFE, 8'h00);
		offer_time(32'hFFFF_FFFE);
		offer_time(32'hFFFF_FFFF);
		offer_time(32'd0);
		offer_time(32'd7);

		// largest durations
		apply_settings(24'hFF_FFFF, 24'hFF_FFFF, 32'd0, 8'hFF);
		offer_time(32'd0);
		offer_time(32'h00FF_FFFF);
		offer_time(32'h01FF_FFFE);
		offer_time(32'hFFFF_FFFF);

		// active while the on duration is rewritten to zero
		apply_settings(24'd5, 24'd3, 32'd0, 8'h3C);
		offer_time(32'd0);
		apply_settings(24'd0, 24'd3, 32'd5, 8'h3C);
		offer_time(32'd5);
		offer_time(32'd8);

		// zero period with an edge due and not due
		apply_settings(24'd0, 24'd0, 32'd100, 8'h01);
		offer_time(32'd200);
		offer_time(32'd50);

		// random phases
		for (int ph = 0; ph < PHASES; ph++) begin
			gap_max = (ph % 4 == 3) ? 0 : 10;
			case (ph % 7)
				0: begin
					on_len = DUR_W'($urandom_range(1, 16));
					off_len = DUR_W'($urandom_range(1, 16));
				end
				1: begin
					on_len = '0;
					off_len = DUR_W'($urandom_range(1, 20));
				end
				2: begin
					on_len = DUR_W'($urandom_range(1, 20));
					off_len = '0;
				end
				3: begin
					on_len = DUR_W'($urandom_range(0, 1000));
					off_len = DUR_W'($urandom_range(0, 1000));
				end
				4: begin
					on_len = DUR_W'($urandom_range(24'h80_0000, 24'hFF_FFFF));
					off_len = DUR_W'($urandom_range(24'h80_0000, 24'hFF_FFFF));
				end
				5: begin
					on_len = ($urandom_range(0, 1) == 0) ? 24'h00_0000 : 24'hFF_FFFF;
					off_len = 24'hFF_FFFF;
				end
				default: begin
					on_len = DUR_W'($urandom_range(0, 3));
					off_len = DUR_W'($urandom_range(0, 3));
				end
			endcase
			per = PERIOD_W'(on_len) + PERIOD_W'(off_len);
			step_max = (per == '0) ? 32'd8 : NOW_W'(per);
			// some phases start just below the wrap point
			if (ph % 3 == 2)
				base = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
			else
				base = $urandom;
			apply_settings(on_len, off_len, base + $urandom_range(0, step_max),
				(ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom));
			clock_now = base;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 31);
				if (sel == 0)
					clock_now = $urandom;
				else if (sel == 1)
					clock_now = clock_now - $urandom_range(0, 4 * step_max);
				else if (sel == 2)
					clock_now = clock_now + $urandom_range(0, 32'h0FFF_FFFF);
				else
					clock_now = clock_now + $urandom_range(0, step_max);
				offer_time(clock_now);
				// sender pause until the block is empty
				if (n == 60 && ph % 2 == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/posch_pkg.sv
src/posch_rem_unit.sv
src/periodic_on_off_scheduler_top.sv
test/on_off_checker.sv
test/tb_periodic_on_off_scheduler_top.sv
